@@ sv/framed_pose_byte_parser_core_defines.svh @@
// Assertion macros shared by the parser RTL.
`ifndef FRAMED_POSE_BYTE_PARSER_CORE_DEFINES_SVH
`define FRAMED_POSE_BYTE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fpbp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FPBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fpbp assertion failed");

`endif

@@ sv/fpbp_pkg.sv @@
// Package for the pose frame parser: codes, widths, reset values and the byte mapping.
package fpbp_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int AXIS_W  = 3;
    localparam int WORD_W  = 32;
    localparam int FIXED_W = 21;
    localparam int CFG_IDX_W = 2;

    // Default number of axes per frame
    localparam int AXIS_COUNT_DEF = 6;

    // Event codes on the result channel
    localparam logic [KIND_W-1:0] EV_AXIS    = 2'd0;
    localparam logic [KIND_W-1:0] EV_ACCEPT  = 2'd1;
    localparam logic [KIND_W-1:0] EV_DISCARD = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd2;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd60;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd62;

    // Byte to Q4.16 (signed) mapping: round(b*131072/17) - 983040.
    // b*131072 = 17*7710*b + 2b, so q = 7710*b + floor((2b+8)/17);
    // the small quotient uses 241/4096, exact for 2b+8 <= 518.
    localparam int MAP_SCALE  = 7710;
    localparam int MAP_RECIP  = 241;
    localparam int MAP_SHIFT  = 12;
    localparam int MAP_OFFSET = 983040;

    // Read phases, one-hot
    typedef enum logic [2:0] {
        ST_WAIT = 3'b001,
        ST_READ = 3'b010,
        ST_END  = 3'b100
    } t_phase;

    function automatic logic signed [FIXED_W-1:0] map_byte(input logic [BYTE_W-1:0] b);
        logic [FIXED_W-1:0] base;
        logic [9:0]         y;
        logic [17:0]        yr;
        logic [FIXED_W-1:0] q;
        base = FIXED_W'(b) * FIXED_W'(MAP_SCALE);
        y    = {1'b0, b, 1'b0} + 10'd8;
        yr   = 18'(y) * 18'(MAP_RECIP);
        q    = base + FIXED_W'(yr[17:MAP_SHIFT]);
        map_byte = $signed(q - FIXED_W'(MAP_OFFSET));
    endfunction

endpackage

@@ sv/framed_pose_byte_parser_core.sv @@
// Pose frame parser: start byte, AXIS_COUNT axis values, end byte; one byte per beat.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_rx_byte
//  out     | output    | o_out_valid / i_out_stall  | o_event_kind, o_axis_number,
//          |           |                            | o_float_bits, o_fixed_value
//  cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_wdata
//
// One byte is taken per cycle unless the input is stalled; its result, if any, shows on the next cycle.
// Results are held in the single result register after the parse logic.
// Reset is synchronous, active low; no clearing pass is needed.
// The input stalls only while a result is held and the output is stalled.
`include "framed_pose_byte_parser_core_defines.svh"

module framed_pose_byte_parser_core #(
    parameter int AXIS_COUNT = fpbp_pkg::AXIS_COUNT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input byte channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [fpbp_pkg::BYTE_W-1:0]           i_rx_byte,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [fpbp_pkg::KIND_W-1:0]           o_event_kind,
    output logic [fpbp_pkg::AXIS_W-1:0]           o_axis_number,
    output logic [fpbp_pkg::WORD_W-1:0]           o_float_bits,
    output logic signed [fpbp_pkg::FIXED_W-1:0]   o_fixed_value,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic [fpbp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [fpbp_pkg::BYTE_W-1:0]           i_cfg_wdata
);
    import fpbp_pkg::*;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXIS_COUNT - 1);

    // configuration
    logic              r_float_mode;
    logic [BYTE_W-1:0] r_start_marker;
    logic [BYTE_W-1:0] r_end_marker;

    // parse state
    t_phase            r_phase,    n_phase;
    logic [AXIS_W-1:0] r_axis,     n_axis;
    logic [1:0]        r_byte_cnt, n_byte_cnt;
    logic [23:0]       r_partial,  n_partial;

    // result register
    logic                      r_out_valid;
    logic [KIND_W-1:0]         r_kind,  n_kind;
    logic [AXIS_W-1:0]         r_axis_out, n_axis_out;
    logic [WORD_W-1:0]         r_float, n_float;
    logic signed [FIXED_W-1:0] r_fixed, n_fixed;
    logic                      n_emit;

    logic in_fire;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_fire    = i_in_valid & ~o_in_stall;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_float_mode   <= 1'b0;
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FLOAT_MODE:   r_float_mode   <= i_cfg_wdata[0];
                CFG_START_MARKER: r_start_marker <= i_cfg_wdata;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // parse one byte
    always_comb begin
        n_phase    = r_phase;
        n_axis     = r_axis;
        n_byte_cnt = r_byte_cnt;
        n_partial  = r_partial;
        n_emit     = 1'b0;
        n_kind     = EV_AXIS;
        n_axis_out = '0;
        n_float    = '0;
        n_fixed    = '0;
        case (r_phase)
            ST_READ: begin
                if (!r_float_mode || r_byte_cnt == 2'd3) begin
                    // axis value complete
                    n_emit     = 1'b1;
                    n_axis_out = r_axis;
                    if (!r_float_mode) begin
                        n_fixed = map_byte(i_rx_byte);
                    end else begin
                        n_float    = {i_rx_byte, r_partial};
                        n_byte_cnt = 2'd0;
                    end
                    if (r_axis < LAST_AXIS) begin
                        n_axis = r_axis + 1'b1;
                    end else begin
                        n_phase = ST_END;
                    end
                end else begin
                    // gather low bytes of the word, LSB first
                    case (r_byte_cnt)
                        2'd0:    n_partial[7:0]   = i_rx_byte;
                        2'd1:    n_partial[15:8]  = i_rx_byte;
                        default: n_partial[23:16] = i_rx_byte;
                    endcase
                    n_byte_cnt = r_byte_cnt + 1'b1;
                end
            end
            ST_END: begin
                n_phase = ST_WAIT;
                n_emit  = 1'b1;
                n_kind  = (i_rx_byte == r_end_marker) ? EV_ACCEPT : EV_DISCARD;
            end
            default: begin
                // waiting for start
                n_phase = ST_WAIT;
                if (i_rx_byte == r_start_marker) begin
                    n_phase = ST_READ;
                    n_axis  = '0;
                end
            end
        endcase
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ST_WAIT;
            r_axis     <= '0;
            r_byte_cnt <= '0;
            r_partial  <= '0;
        end else if (in_fire) begin
            r_phase    <= n_phase;
            r_axis     <= n_axis;
            r_byte_cnt <= n_byte_cnt;
            r_partial  <= n_partial;
        end
    end

    // result valid: hold while stalled, else load from the accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= in_fire & n_emit;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind     <= n_kind;
            r_axis_out <= n_axis_out;
            r_float    <= n_float;
            r_fixed    <= n_fixed;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_kind;
    assign o_axis_number = r_axis_out;
    assign o_float_bits  = r_float;
    assign o_fixed_value = r_fixed;

    // checks
    `FPBP_ASSERT_IMP(a_frame_evt_clean, i_clk, i_rst_n, o_out_valid && o_event_kind != EV_AXIS, o_axis_number == '0 && o_float_bits == '0 && o_fixed_value == '0)
    `FPBP_ASSERT_NXT(a_end_emits, i_clk, i_rst_n, in_fire && r_phase == ST_END, o_out_valid && o_event_kind != EV_AXIS && r_phase == ST_WAIT)
    `FPBP_ASSERT_IMP(a_axis_range, i_clk, i_rst_n, r_phase == ST_READ, r_axis <= LAST_AXIS)

endmodule

@@ test/framed_pose_byte_parser_core_tb.sv @@
// Self-checking testbench for the pose frame parser: directed frames, then random byte streams.
`timescale 1ns / 100ps

module framed_pose_byte_parser_core_tb;
    import fpbp_pkg::*;

    // Register index with no register behind it; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // One byte step of -15..+15 over 0..255 in Q16 is 131072/17
    localparam int Q16_STEP_NUM = 131072;
    localparam int Q16_STEP_DEN = 17;
    localparam int Q16_ZERO_OFS = 983040;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [AXIS_W-1:0]         axis;
        logic [WORD_W-1:0]         bits;
        logic signed [FIXED_W-1:0] fixed;
    } t_pose_event;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [BYTE_W-1:0]          i_rx_byte;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [KIND_W-1:0]          o_event_kind;
    logic [AXIS_W-1:0]          o_axis_number;
    logic [WORD_W-1:0]          o_float_bits;
    logic signed [FIXED_W-1:0]  o_fixed_value;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_idx;
    logic [BYTE_W-1:0]          i_cfg_wdata;

    // Parser state tracked on the testbench side
    bit                 cfg_float;
    logic [BYTE_W-1:0]  cfg_start;
    logic [BYTE_W-1:0]  cfg_end;
    t_phase             frame_phase;
    logic [AXIS_W-1:0]  axis_idx;
    logic [1:0]         word_pos;
    logic [23:0]        word_low;

    t_pose_event pose_events_due[$];
    int          fail_count;
    int          cycle_count;
    bit          calm_run;

    framed_pose_byte_parser_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_kind  (o_event_kind),
        .o_axis_number (o_axis_number),
        .o_float_bits  (o_float_bits),
        .o_fixed_value (o_fixed_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= !calm_run && ($urandom_range(99) < 6);
    end

    // Linear map of a data byte to Q4.16 (signed), rounded to nearest
    function automatic logic signed [FIXED_W-1:0] byte_to_q16(input logic [BYTE_W-1:0] b);
        int q;
        q = (int'(b) * Q16_STEP_NUM + Q16_STEP_DEN / 2) / Q16_STEP_DEN;
        return FIXED_W'(q - Q16_ZERO_OFS);
    endfunction

    // Advance the tracked parser by one accepted byte, queue the event it causes
    task automatic track_frame_byte(input logic [BYTE_W-1:0] b);
        t_pose_event ev;
        bit          axis_ready;
        ev = '0;
        axis_ready = 1'b0;
        case (frame_phase)
            ST_READ: begin
                ev.kind = EV_AXIS;
                ev.axis = axis_idx;
                if (!cfg_float) begin
                    ev.fixed = byte_to_q16(b);
                    axis_ready = 1'b1;
                end else if (word_pos < 2'd3) begin
                    // low bytes of the word; position survives frames and mode changes
                    word_low[word_pos*8 +: 8] = b;
                    word_pos = word_pos + 2'd1;
                end else begin
                    word_pos = 2'd0;
                    ev.bits = {b, word_low};
                    axis_ready = 1'b1;
                end
            end
            ST_END: begin
                frame_phase = ST_WAIT;
                ev.kind = (b == cfg_end) ? EV_ACCEPT : EV_DISCARD;
                pose_events_due.push_back(ev);
            end
            default: begin
                frame_phase = ST_WAIT;
                if (b == cfg_start) begin
                    frame_phase = ST_READ;
                    axis_idx = '0;
                end
            end
        endcase
        if (axis_ready) begin
            pose_events_due.push_back(ev);
            if (axis_idx < AXIS_W'(AXIS_COUNT_DEF - 1))
                axis_idx = axis_idx + 1'b1;
            else
                frame_phase = ST_END;
        end
    endtask

    // Result check, register and input beat tracking
    always @(posedge i_clk) begin : beat_monitor
        t_pose_event want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pose_events_due.size() == 0) begin
                    $error("unexpected result beat: kind %0d axis %0d",
                           o_event_kind, o_axis_number);
                    fail_count++;
                end else begin
                    want = pose_events_due.pop_front();
                    if (o_event_kind !== want.kind) begin
                        $error("event_kind: expected %0d, actual %0d", want.kind, o_event_kind);
                        fail_count++;
                    end
                    if (o_axis_number !== want.axis) begin
                        $error("axis_number: expected %0d, actual %0d",
                               want.axis, o_axis_number);
                        fail_count++;
                    end
                    if (o_float_bits !== want.bits) begin
                        $error("float_bits: expected %h, actual %h", want.bits, o_float_bits);
                        fail_count++;
                    end
                    if (o_fixed_value !== want.fixed) begin
                        $error("fixed_value: expected %0d, actual %0d",
                               $signed(want.fixed), $signed(o_fixed_value));
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FLOAT_MODE:   cfg_float = i_cfg_wdata[0];
                    CFG_START_MARKER: cfg_start = i_cfg_wdata;
                    CFG_END_MARKER:   cfg_end = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall)
                track_frame_byte(i_rx_byte);
        end
    end

    // Random data byte, leaning on the extremes now and then
    function automatic logic [BYTE_W-1:0] rand_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        return BYTE_W'($urandom);
    endfunction

    // Send one byte beat, with random idle cycles ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!calm_run && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // Drop valid, wait for all due events, then let the pipeline drain
    task automatic settle();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pose_events_due.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write all three registers back to back, optionally poking the unused index first
    task automatic apply_setup(input bit fm, input logic [BYTE_W-1:0] sm,
                               input logic [BYTE_W-1:0] em, input bit poke_unused);
        if (poke_unused) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= CFG_UNUSED;
            i_cfg_wdata <= BYTE_W'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_FLOAT_MODE;
        i_cfg_wdata <= {7'($urandom), fm};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_START_MARKER;
        i_cfg_wdata <= sm;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_END_MARKER;
        i_cfg_wdata <= em;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Byte mode at reset markers: noise, an accepted frame, a discarded frame
    task automatic test_byte_frames();
        logic [BYTE_W-1:0] bytes[$];
        bytes = '{8'd62, 8'd0, 8'd60, 8'd0, 8'd255, 8'd127, 8'd128, 8'd1, 8'd254, 8'd62,
                  8'd60, 8'd17, 8'd34, 8'd51, 8'd68, 8'd85, 8'd102, 8'd61};
        foreach (bytes[i])
            send_byte(bytes[i]);
        settle();
    endtask

    // Float word, then a switch to byte mode in the middle of a frame with a partial word
    task automatic test_float_mode_switch();
        apply_setup(1'b1, START_MARKER_RST, END_MARKER_RST, 1'b1);
        send_byte(8'd60);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h3F);
        send_byte(8'hFF);
        send_byte(8'hFF);
        settle();
        apply_setup(1'b0, START_MARKER_RST, END_MARKER_RST, 1'b1);
        send_byte(8'd0);
        send_byte(8'd255);
        send_byte(8'd128);
        send_byte(8'd64);
        send_byte(8'd200);
        send_byte(8'd62);
        settle();
    endtask

    // Random streams: mostly well-formed frames, plus noise and cut-short frames
    task automatic test_random_streams();
        bit                fm;
        logic [BYTE_W-1:0] sm;
        logic [BYTE_W-1:0] em;
        int                sent;
        int                n;
        int                k;
        int unsigned       r;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin fm = 1'b0; sm = 8'd0;   em = 8'd255; end
                1: begin fm = 1'b1; sm = 8'd255; em = 8'd0;   end
                2: begin fm = 1'b0; sm = 8'd255; em = 8'd255; end
                3: begin fm = 1'b1; sm = 8'd0;   em = 8'd0;   end
                default: begin
                    fm = 1'($urandom);
                    sm = BYTE_W'($urandom);
                    em = ($urandom_range(3) == 0) ? sm : BYTE_W'($urandom);
                end
            endcase
            settle();
            calm_run = (ph == 5);
            apply_setup(fm, sm, em, (ph % 3) == 0);
            sent = 0;
            while (sent < 92) begin
                r = $urandom_range(99);
                n = cfg_float ? 4 * AXIS_COUNT_DEF : AXIS_COUNT_DEF;
                if (r < 75) begin
                    send_byte(cfg_start);
                    repeat (n) send_byte(rand_byte());
                    send_byte(($urandom_range(99) < 85) ? cfg_end : rand_byte());
                    sent += n + 2;
                end else if (r < 90) begin
                    repeat ($urandom_range(1, 4)) send_byte(rand_byte());
                end else begin
                    k = $urandom_range(1, n);
                    send_byte(cfg_start);
                    repeat (k) send_byte(rand_byte());
                    sent += k + 1;
                end
            end
        end
        calm_run = 1'b0;
        settle();
    endtask

    initial begin
        cfg_float   = 1'b0;
        cfg_start   = START_MARKER_RST;
        cfg_end     = END_MARKER_RST;
        frame_phase = ST_WAIT;
        axis_idx    = '0;
        word_pos    = '0;
        word_low    = '0;
        fail_count  = 0;
        cycle_count = 0;
        calm_run    = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_rx_byte   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_FLOAT_MODE;
        i_cfg_wdata <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_byte_frames();
        test_float_mode_switch();
        test_random_streams();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
